// ----- rtl/core/qjb_pkg.sv -----
// Shared constants for the quintic joint blend core.
package qjb_pkg;

    localparam int unsigned BLEND_C3 = 10;
    localparam int unsigned BLEND_C4 = 15;
    localparam int unsigned BLEND_C5 = 6;
    localparam int unsigned TOTAL_STEPS_RESET = 100;

endpackage

// ----- rtl/core/quintic_joint_blend_core.sv -----
// Quintic joint blend core: minimum-jerk joint sample pipeline.
// Throughput: one transaction per cycle while the output is ready or holds no valid result;
// the phase divider retires one quotient bit per stage and every stage advances together under that condition.
// Reset: rst_n asynchronous, clears all valid bits, total_steps returns to 100.
module quintic_joint_blend_core
    import qjb_pkg::*;
#(
    parameter int POSITION_WIDTH      = 16,
    parameter int PHASE_FRACTION_BITS = 16,
    parameter int STEP_WIDTH          = 12
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [STEP_WIDTH-1:0]    cfg_wr_data,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // start_position, target_position, step_index, zero pad
    input  logic [((2*POSITION_WIDTH+STEP_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // position, zero pad
    output logic [((POSITION_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    output logic                     m_axis_tlast
);

    localparam int P   = POSITION_WIDTH;
    localparam int F   = PHASE_FRACTION_BITS;
    localparam int SW  = STEP_WIDTH;
    localparam int TW  = F + 1;
    localparam int QW  = F + 5;
    localparam int RW  = SW + 1;
    localparam int AW  = P + F + 3;
    localparam int NS  = F + 7;
    localparam int OUT_W = ((P + 7) / 8) * 8;

    localparam logic [TW-1:0]      PH_ONE  = {1'b1, {F{1'b0}}};
    localparam logic [2*TW-1:0]    HALF_T  = (2*TW)'(1) << (F - 1);
    localparam logic [TW+QW-1:0]   HALF_S  = (TW+QW)'(1) << (F - 1);
    localparam logic signed [AW-1:0] HALF_A = AW'(1) << (F - 1);
    localparam logic signed [P+2:0] PMAX = (P+3)'((1 << (P - 1)) - 1);
    localparam logic signed [P+2:0] PMIN = -PMAX - (P+3)'(1);

    typedef struct packed {
        logic signed [P-1:0] start;
        logic signed [P-1:0] target;
        logic                fin;
    } side_t;

    logic [SW-1:0] total_steps_reg;
    logic [NS-1:0] vld_reg;
    side_t         side_reg [NS];
    logic [RW-1:0] rem_reg  [F+1];
    logic [F-1:0]  quot_reg [F+1];
    logic [TW-1:0] t1_reg, t2_reg, t_b2_reg, t3_reg, s_reg;
    logic [QW-1:0] q_reg;
    logic signed [P+F+1:0] p0_reg, p1_reg;
    logic signed [P-1:0]   pos_reg;
    logic                  adv;

    logic [SW-1:0]   in_step;
    logic            in_fin;
    logic [RW-1:0]   rem_next  [F+1];
    logic [F-1:0]    quot_next [F+1];
    logic [TW-1:0]   t_next, t2_next, t3_next, s_next, oms;
    logic [2*TW-1:0] sq_prod, cu_prod;
    logic [QW-1:0]   q_pos, q_neg, q_next;
    logic [TW+QW-1:0] s_prod, s_rnd;
    logic signed [AW-1:0]  acc;
    logic signed [P+2:0]   pos_wide;
    logic signed [P-1:0]   pos_next;

    assign adv           = !vld_reg[NS-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[NS-1];
    assign m_axis_tlast  = side_reg[NS-1].fin;
    assign m_axis_tdata  = OUT_W'($unsigned(pos_reg));

    assign in_step = s_axis_tdata[2*P +: SW];
    assign in_fin  = (total_steps_reg == '0) || (in_step >= total_steps_reg);

    always_comb
    begin
        rem_next[0]  = '0;
        quot_next[0] = '0;
        for (int k = 1; k <= F; k++)
        begin
            logic [RW-1:0] sh;
            sh = {rem_reg[k-1][RW-2:0], 1'b0};
            if (sh >= {1'b0, total_steps_reg})
            begin
                rem_next[k]  = sh - {1'b0, total_steps_reg};
                quot_next[k] = {quot_reg[k-1][F-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = sh;
                quot_next[k] = {quot_reg[k-1][F-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        t_next  = side_reg[F].fin ? PH_ONE : {1'b0, quot_reg[F]};
        sq_prod = {{TW{1'b0}}, t1_reg} * {{TW{1'b0}}, t1_reg};
        t2_next = TW'((sq_prod + HALF_T) >> F);
        cu_prod = {{TW{1'b0}}, t2_reg} * {{TW{1'b0}}, t_b2_reg};
        t3_next = TW'((cu_prod + HALF_T) >> F);
        q_pos   = QW'(BLEND_C5) * QW'(t2_reg) + (QW'(BLEND_C3) << F);
        q_neg   = QW'(BLEND_C4) * QW'(t_b2_reg);
        q_next  = (q_pos > q_neg) ? (q_pos - q_neg) : '0;
        s_prod  = (TW+QW)'(t3_reg) * (TW+QW)'(q_reg);
        s_rnd   = (s_prod + HALF_S) >> F;
        s_next  = (s_rnd > (TW+QW)'(PH_ONE)) ? PH_ONE : TW'(s_rnd);
        oms     = PH_ONE - s_reg;
        acc     = AW'(p0_reg) + AW'(p1_reg) + HALF_A;
        pos_wide = (P+3)'(acc >>> F);
        if (pos_wide > PMAX)
            pos_next = P'(PMAX);
        else if (pos_wide < PMIN)
            pos_next = P'(PMIN);
        else
            pos_next = P'(pos_wide);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_steps_reg <= SW'(TOTAL_STEPS_RESET);
            vld_reg         <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                total_steps_reg <= cfg_wr_data;
            if (adv)
                vld_reg <= {vld_reg[NS-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0].start  <= s_axis_tdata[0 +: P];
            side_reg[0].target <= s_axis_tdata[P +: P];
            side_reg[0].fin    <= in_fin;
            rem_reg[0]         <= {1'b0, in_step};
            quot_reg[0]        <= '0;
            for (int i = 1; i < NS; i++)
                side_reg[i] <= side_reg[i-1];
            for (int k = 1; k <= F; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                quot_reg[k] <= quot_next[k];
            end
            t1_reg   <= t_next;
            t2_reg   <= t2_next;
            t_b2_reg <= t1_reg;
            t3_reg   <= t3_next;
            q_reg    <= q_next;
            s_reg    <= s_next;
            p0_reg   <= side_reg[F+4].start * $signed({1'b0, oms});
            p1_reg   <= side_reg[F+4].target * $signed({1'b0, s_reg});
            pos_reg  <= pos_next;
        end
    end

endmodule

// ----- dv/testbench.sv -----
// Testbench for quintic_joint_blend_core: directed table and random joint samples vs. a predictor.
module testbench;
    import qjb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PW = 16;
    localparam int FB = 16;
    localparam int SW = 12;
    localparam int IN_W = ((2*PW+SW+7)/8)*8;
    localparam int OUT_W = ((PW+7)/8)*8;
    localparam int PIPE_LAT = FB + 7;
    localparam longint ONE = 64'd1 << FB;
    localparam longint HALF = 64'd1 << (FB-1);

    typedef struct packed {
        logic signed [PW-1:0] position;
        logic                 final_step;
    } sample_t;

    typedef struct {
        logic signed [PW-1:0] start_pos;
        logic signed [PW-1:0] target_pos;
        logic [SW-1:0]        step;
        logic                 known;
        logic signed [PW-1:0] known_pos;
        logic                 known_final;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [SW-1:0] cfg_wr_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic m_axis_tlast;

    logic [SW-1:0] steps_cfg = SW'(TOTAL_STEPS_RESET);
    sample_t expected_samples[$];
    int mismatches = 0;
    bit sending_done = 1'b0;

    quintic_joint_blend_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint rnd_frac(longint x);
        return (x + HALF) >>> FB;
    endfunction

    function automatic sample_t predict_blend(logic signed [PW-1:0] sp,
                                              logic signed [PW-1:0] tp,
                                              logic [SW-1:0] step);
        sample_t r;
        longint t, t2, t3, q, s, acc, pos;
        longint pmax, pmin;
        pmax = (64'd1 << (PW-1)) - 1;
        pmin = -pmax - 1;
        r.final_step = (steps_cfg == 0) || (step >= steps_cfg);
        if (r.final_step)
            t = ONE;
        else
            t = (longint'(step) << FB) / longint'(steps_cfg);
        t2 = rnd_frac(t * t);
        t3 = rnd_frac(t2 * t);
        q = longint'(BLEND_C5) * t2 + longint'(BLEND_C3) * ONE - longint'(BLEND_C4) * t;
        if (q < 0)
            q = 0;
        s = rnd_frac(t3 * q);
        if (s > ONE)
            s = ONE;
        acc = longint'(sp) * (ONE - s) + longint'(tp) * s + HALF;
        pos = acc >>> FB;
        if (pos > pmax)
            pos = pmax;
        if (pos < pmin)
            pos = pmin;
        r.position = pos[PW-1:0];
        return r;
    endfunction

    task automatic send_sample(logic signed [PW-1:0] sp, logic signed [PW-1:0] tp,
                               logic [SW-1:0] step);
        int gap;
        gap = $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata <= IN_W'({step, tp, sp});
        s_axis_tvalid <= 1'b1;
        expected_samples = {expected_samples, predict_blend(sp, tp, step)};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_steps(logic [SW-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (expected_samples.size() != 0)
            @(negedge clk);
        repeat (PIPE_LAT + 4) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        steps_cfg = v;
    endtask

    // output side: random stalls, compare each transaction with oldest expectation
    initial
    begin
        int stall;
        sample_t got, want;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            got.position = m_axis_tdata[PW-1:0];
            got.final_step = m_axis_tlast;
            if (expected_samples.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction pos=%0d last=%0b",
                             got.position, got.final_step);
            end
            else
            begin
                want = expected_samples.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp pos=%0d last=%0b got pos=%0d last=%0b",
                                 want.position, want.final_step,
                                 got.position, got.final_step);
                end
            end
        end
    end

    initial
    begin
        dir_row_t rows [11];
        dir_row_t r;
        logic signed [PW-1:0] sp, tp;
        logic [SW-1:0] step;
        int n;
        sample_t pred;

        rows = '{
            '{16'sd0, 16'sd4096, 12'd100, 1'b1, 16'sd4096, 1'b1},
            '{16'sd0, 16'sd4096, 12'd0, 1'b1, 16'sd0, 1'b0},
            '{16'sd1234, -16'sd999, 12'd4095, 1'b1, -16'sd999, 1'b1},
            '{-16'sd32768, 16'sd32767, 12'd50, 1'b0, 16'sd0, 1'b0},
            '{16'sd32767, -16'sd32768, 12'd50, 1'b0, 16'sd0, 1'b0},
            '{-16'sd32768, 16'sd32767, 12'd1, 1'b0, 16'sd0, 1'b0},
            '{-16'sd32768, 16'sd32767, 12'd99, 1'b0, 16'sd0, 1'b0},
            '{16'sd32767, 16'sd32767, 12'd37, 1'b1, 16'sd32767, 1'b0},
            '{-16'sd32768, -16'sd32768, 12'd63, 1'b1, -16'sd32768, 1'b0},
            '{16'sd100, -16'sd100, 12'd101, 1'b1, -16'sd100, 1'b1},
            '{16'sd5, 16'sd7, 12'd2048, 1'b1, 16'sd7, 1'b1}
        };

        rst_n = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            r = rows[i];
            pred = predict_blend(r.start_pos, r.target_pos, r.step);
            if (r.known && (pred.position !== r.known_pos || pred.final_step !== r.known_final))
            begin
                mismatches++;
                $display("table row %0d disagrees with predictor", i);
            end
            send_sample(r.start_pos, r.target_pos, r.step);
        end

        write_steps(12'd1);
        send_sample(16'sd300, -16'sd300, 12'd0);
        send_sample(16'sd300, -16'sd300, 12'd1);
        write_steps(12'd0);
        send_sample(16'sd300, -16'sd300, 12'd0);
        send_sample(-16'sd1, 16'sd2, 12'd5);
        write_steps(12'd4095);
        send_sample(-16'sd32768, 16'sd32767, 12'd4094);
        send_sample(-16'sd32768, 16'sd32767, 12'd2047);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: write_steps(12'd4095);
                1: write_steps(12'd1);
                2: write_steps(12'd0);
                default: write_steps(SW'($urandom_range(1, 4095)));
            endcase
            for (n = 0; n < 100; n++)
            begin
                sp = PW'($urandom);
                tp = PW'($urandom);
                if ($urandom_range(0, 3) == 0)
                    step = SW'($urandom);
                else if (steps_cfg != 0)
                    step = SW'($urandom_range(0, steps_cfg));
                else
                    step = SW'($urandom);
                send_sample(sp, tp, step);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_samples.size() != 0)
            @(negedge clk);
        repeat (PIPE_LAT + 20) @(negedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end
endmodule
